### design/resampling_kernel_weight_fixed_top_defines.svh
// assertion macros for the resampling kernel weight block
`ifndef RESAMPLING_KERNEL_WEIGHT_FIXED_TOP_DEFINES_SVH
`define RESAMPLING_KERNEL_WEIGHT_FIXED_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define RKW_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define RKW_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/rkw_pkg.sv
// types and constants of the resampling kernel weight block
package rkw_pkg;

    // kernel selection codes
    typedef enum logic [1:0] {
        KM_BOX      = 2'd0,
        KM_BILINEAR = 2'd1,
        KM_HERMITE  = 2'd2,
        KM_BICUBIC  = 2'd3
    } kmode_t;

    // register indexes
    localparam logic CFG_KERNEL_MODE    = 1'b0;
    localparam logic CFG_BOX_HALF_WIDTH = 1'b1;

    // register reset values
    localparam kmode_t      KMODE_RESET = KM_BICUBIC;
    localparam logic [14:0] BOX_HW_RESET = 15'd128;

    // field widths
    localparam int DIST_W   = 16;
    localparam int WEIGHT_W = 9;
    localparam int CFG_W    = 15;

    // support limits in .8 units
    localparam logic [16:0] INNER_LIMIT = 17'd256;
    localparam logic [16:0] OUTER_LIMIT = 17'd512;

    // linear terms of the cubics
    localparam logic signed [11:0] HERM_LIN_OFF = 12'sd768;   // 3 * 256
    localparam logic signed [11:0] BIC_LIN_OFF  = 12'sd1280;  // 5 * 256
    localparam logic [10:0]        BIC_OUTER_C  = 11'd1280;   // 5 * 256
    localparam logic signed [19:0] BIC_LOBE_OFF = 20'sd262144; // 4 * 256 * 256

    // .24 constants and rounding
    localparam logic signed [29:0] ONE_24   = 30'sd16777216;  // 256 << 16
    localparam logic signed [29:0] TWO_24   = 30'sd33554432;  // 2 * 256 << 16
    localparam logic signed [29:0] RND_HALF = 30'sd32768;     // 0x8000

    // byte-scale knee
    localparam logic signed [13:0] BYTE_KNEE = 14'sd128;
    localparam logic [8:0]         FULL_W    = 9'd255;

endpackage

### design/resampling_kernel_weight_fixed_top.sv
// resampling kernel weight generator, four-stage pipeline
//
//  port group  | direction | handshake           | payload
//  ------------+-----------+---------------------+------------------------------
//  input       | in        | in_valid / in_stall | distance (16 bit signed, .8)
//  output      | out       | out_valid/out_stall | weight (9 bit signed)
//  config      | in        | cfg_we              | cfg_index, cfg_data
//
// one beat per cycle sustained while out_stall is low; each beat passes the
// stages in order (abs and box/tent, first product, second product, round)
// the two multiplier stages set the depth; each stage holds only while the
// stage after it is full and held, so in_stall rises only when every stage
// holds a beat and out_stall is high
// reset clears the stage valid bits and loads kernel_mode 3, box_half_width 128

`include "resampling_kernel_weight_fixed_top_defines.svh"

module resampling_kernel_weight_fixed_top (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic signed [rkw_pkg::DIST_W-1:0]  distance,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic signed [rkw_pkg::WEIGHT_W-1:0] weight,
    input  logic                               cfg_we,
    input  logic                               cfg_index,
    input  logic        [rkw_pkg::CFG_W-1:0]   cfg_data
);

    // configuration registers
    rkw_pkg::kmode_t kernel_mode_reg;
    logic [14:0]     box_half_width_reg;

    // stage valid bits
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic ready1, ready2, ready3, ready4;
    logic pipe_full;

    // stage 1 payload
    rkw_pkg::kmode_t s1_mode_reg;
    logic [8:0]      s1_a_reg;
    logic            s1_inner_reg;
    logic            s1_outer_reg;
    logic [8:0]      s1_simple_reg;

    // stage 2 payload
    rkw_pkg::kmode_t   s2_mode_reg;
    logic [8:0]        s2_a_reg;
    logic              s2_inner_reg;
    logic              s2_outer_reg;
    logic [8:0]        s2_simple_reg;
    logic [18:0]       s2_p1_reg;
    logic signed [11:0] s2_g_reg;

    // stage 3 payload
    rkw_pkg::kmode_t    s3_mode_reg;
    logic               s3_inner_reg;
    logic               s3_outer_reg;
    logic [8:0]         s3_simple_reg;
    logic signed [29:0] s3_p2_reg;

    // output register
    logic signed [8:0] weight_reg;

    // stage 1 combinational
    logic signed [16:0] d_ext;
    logic signed [16:0] h_ext;
    logic [16:0]        a_full;
    logic [8:0]         a_next;
    logic               inner_next;
    logic               outer_next;
    logic               box_in;
    logic [8:0]         bil_w;
    logic [8:0]         simple_next;

    // stage 2 combinational
    logic [10:0]        f_next;
    logic [19:0]        p1_prod;
    logic [11:0]        lin_u;
    logic signed [11:0] g_next;

    // stage 3 combinational
    logic signed [19:0] x_op;
    logic [18:0]        y_op;
    logic signed [38:0] p2_prod;

    // stage 4 combinational
    logic signed [29:0] p2_adj;
    logic signed [29:0] p2_half;
    logic signed [29:0] p2_sel;
    logic signed [29:0] v24;
    logic signed [13:0] r8;
    logic signed [13:0] w14;
    logic signed [8:0]  weight_next;

    // stall chain, each stage moves when the one ahead frees up
    assign ready4   = !v4_reg || !out_stall;
    assign ready3   = !v3_reg || ready4;
    assign ready2   = !v2_reg || ready3;
    assign ready1   = !v1_reg || ready2;
    assign in_stall = !ready1;

    // every stage holds a beat
    assign pipe_full = v1_reg && v2_reg && v3_reg && v4_reg;

    assign out_valid = v4_reg;
    assign weight    = weight_reg;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kernel_mode_reg    <= rkw_pkg::KMODE_RESET;
            box_half_width_reg <= rkw_pkg::BOX_HW_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                rkw_pkg::CFG_KERNEL_MODE:
                    kernel_mode_reg <= rkw_pkg::kmode_t'(cfg_data[1:0]);
                rkw_pkg::CFG_BOX_HALF_WIDTH:
                    box_half_width_reg <= cfg_data;
                default:
                    kernel_mode_reg <= kernel_mode_reg;
            endcase
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (ready1)
            begin
                v1_reg <= in_valid;
            end
            if (ready2)
            begin
                v2_reg <= v1_reg;
            end
            if (ready3)
            begin
                v3_reg <= v2_reg;
            end
            if (ready4)
            begin
                v4_reg <= v3_reg;
            end
        end
    end

    // stage 1: magnitude, support flags, box and tent weights
    always_comb
    begin
        d_ext      = {distance[15], distance};
        h_ext      = $signed({2'b00, box_half_width_reg});
        a_full     = distance[15] ? 17'(-d_ext) : 17'(d_ext);
        a_next     = a_full[8:0];
        inner_next = (a_full < rkw_pkg::INNER_LIMIT);
        outer_next = !inner_next && (a_full < rkw_pkg::OUTER_LIMIT);
        box_in     = (d_ext >= -h_ext) && (d_ext < h_ext);
        if (!inner_next)
        begin
            bil_w = 9'd0;
        end
        else if (a_next[7])
        begin
            bil_w = 9'd256 - a_next;
        end
        else
        begin
            bil_w = 9'd255 - a_next;
        end
        if (kernel_mode_reg == rkw_pkg::KM_BOX)
        begin
            simple_next = box_in ? rkw_pkg::FULL_W : 9'd0;
        end
        else
        begin
            simple_next = bil_w;
        end
    end

    // stage 2: first product and linear coefficient
    always_comb
    begin
        f_next  = s1_outer_reg ? 11'(rkw_pkg::BIC_OUTER_C - {2'b00, s1_a_reg})
                               : {2'b00, s1_a_reg};
        p1_prod = {9'b0, f_next} * {11'b0, s1_a_reg};
        if (s1_mode_reg == rkw_pkg::KM_HERMITE)
        begin
            lin_u  = {2'b00, s1_a_reg, 1'b0};
            g_next = $signed(lin_u) - rkw_pkg::HERM_LIN_OFF;
        end
        else
        begin
            lin_u  = {2'b00, s1_a_reg, 1'b0} + {3'b000, s1_a_reg};
            g_next = $signed(lin_u) - rkw_pkg::BIC_LIN_OFF;
        end
    end

    // stage 3: second product
    always_comb
    begin
        if (s2_outer_reg)
        begin
            x_op = $signed({2'b00, s2_p1_reg[18:1]}) - rkw_pkg::BIC_LOBE_OFF;
            y_op = {10'b0, s2_a_reg};
        end
        else
        begin
            x_op = {{8{s2_g_reg[11]}}, s2_g_reg};
            y_op = s2_p1_reg;
        end
        p2_prod = x_op * $signed({1'b0, y_op});
    end

    // stage 4: halve toward zero, offset, round to .8, byte scale
    always_comb
    begin
        p2_adj  = s3_p2_reg + $signed({29'b0, s3_p2_reg[29]});
        p2_half = p2_adj >>> 1;
        p2_sel  = ((s3_mode_reg == rkw_pkg::KM_BICUBIC) && s3_inner_reg) ? p2_half
                                                                         : s3_p2_reg;
        v24     = p2_sel + (s3_outer_reg ? rkw_pkg::TWO_24 : rkw_pkg::ONE_24)
                + rkw_pkg::RND_HALF;
        r8      = v24[29:16];
        w14     = (r8 >= rkw_pkg::BYTE_KNEE) ? r8 - 14'sd1 : r8;
        unique case (s3_mode_reg) inside
            rkw_pkg::KM_BOX, rkw_pkg::KM_BILINEAR:
                weight_next = $signed(s3_simple_reg);
            rkw_pkg::KM_HERMITE:
                weight_next = s3_inner_reg ? w14[8:0] : 9'sd0;
            rkw_pkg::KM_BICUBIC:
                weight_next = (s3_inner_reg || s3_outer_reg) ? w14[8:0] : 9'sd0;
            default:
                weight_next = 9'sd0;
        endcase
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (ready1 && in_valid)
        begin
            s1_mode_reg   <= kernel_mode_reg;
            s1_a_reg      <= a_next;
            s1_inner_reg  <= inner_next;
            s1_outer_reg  <= outer_next;
            s1_simple_reg <= simple_next;
        end
        if (ready2 && v1_reg)
        begin
            s2_mode_reg   <= s1_mode_reg;
            s2_a_reg      <= s1_a_reg;
            s2_inner_reg  <= s1_inner_reg;
            s2_outer_reg  <= s1_outer_reg;
            s2_simple_reg <= s1_simple_reg;
            s2_p1_reg     <= p1_prod[18:0];
            s2_g_reg      <= g_next;
        end
        if (ready3 && v2_reg)
        begin
            s3_mode_reg   <= s2_mode_reg;
            s3_inner_reg  <= s2_inner_reg;
            s3_outer_reg  <= s2_outer_reg;
            s3_simple_reg <= s2_simple_reg;
            s3_p2_reg     <= p2_prod[29:0];
        end
        if (ready4 && v3_reg)
        begin
            weight_reg <= weight_next;
        end
    end

    // checks
    `RKW_ASSERT_NOW(a_stall_full, in_stall, pipe_full && out_stall, "in_stall with a free stage")
    `RKW_ASSERT_NEXT(a_stage_moves, v3_reg && ready4, out_valid, "beat lost at output")
    `RKW_ASSERT_NOW(a_weight_range, out_valid, weight >= -9'sd32, "weight below lobe minimum")
    `RKW_ASSERT_NOW(a_support_flags, v1_reg, !(s1_inner_reg && s1_outer_reg), "both flags set")

endmodule
